// ===== src/lwpb_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU write-back page buffer package
// Constants, codes and types shared by the page buffer directory and its top.
// ----------------------------------------------------------------------------
package lwpb_pkg;

   localparam int SLOTS      = 8;
   localparam int PAGE_BYTES = 512;
   localparam int INDEX_BITS = 24;

   localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_BITS  = $clog2(SLOTS + 1);
   localparam int OFFSET_BITS = $clog2(PAGE_BYTES);
   localparam int PAGE_BITS   = INDEX_BITS - OFFSET_BITS;
   localparam int CAP_BITS    = 4;
   localparam int SIZE_BITS   = 25;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = SIZE_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUFFER_CAPACITY = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARRAY_SIZE      = 1'd1;

   localparam logic [CAP_BITS-1:0]  CAP_RESET  = 4'd8;
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = '0;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic                   status;
      logic                   hit;
      logic [SLOT_BITS-1:0]   slot;
      logic [PAGE_BITS-1:0]   page_number;
      logic [OFFSET_BITS-1:0] page_offset;
      logic                   evict_valid;
      logic [PAGE_BITS-1:0]   evicted_page;
      logic                   writeback_needed;
   } lwpb_result_type;

endpackage

// ===== src/lwpb_directory.sv =====
// ----------------------------------------------------------------------------
// LRU write-back page buffer directory
// Slot state, associative page lookup, free slot and LRU victim selection,
// and the rank and dirty updates for one access per cycle.
// ----------------------------------------------------------------------------
module lwpb_directory (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic                            operation,
   input  logic [lwpb_pkg::INDEX_BITS-1:0] element_index,
   input  logic [lwpb_pkg::CAP_BITS-1:0]   buffer_capacity,
   input  logic [lwpb_pkg::SIZE_BITS-1:0]  array_size,
   output lwpb_pkg::lwpb_result_type       result
);
   import lwpb_pkg::*;

   logic [SLOTS-1:0]                    slot_valid_ff, slot_valid_in;
   logic [SLOTS-1:0][PAGE_BITS-1:0]     slot_page_ff, slot_page_in;
   logic [SLOTS-1:0]                    slot_dirty_ff, slot_dirty_in;
   logic [SLOTS-1:0][SLOT_BITS-1:0]     slot_rank_ff, slot_rank_in;

   logic                   in_range;
   logic [PAGE_BITS-1:0]   page;
   logic [OFFSET_BITS-1:0] offset;
   logic [COUNT_BITS-1:0]  cap_eff;
   logic [COUNT_BITS-1:0]  count;
   logic                   hit;
   logic [SLOT_BITS-1:0]   hit_slot;
   logic                   free_found;
   logic [SLOT_BITS-1:0]   free_slot;
   logic [SLOT_BITS-1:0]   best_rank;
   logic [SLOT_BITS-1:0]   victim_slot;
   logic                   fill;
   logic                   evict;
   logic [SLOT_BITS-1:0]   sel;

   assign in_range = {1'b0, element_index} < array_size;
   assign page     = element_index[INDEX_BITS-1:OFFSET_BITS];
   assign offset   = element_index[OFFSET_BITS-1:0];
   assign count    = COUNT_BITS'($countones(slot_valid_ff));

   always_comb begin
      if (buffer_capacity == '0) begin
         cap_eff = COUNT_BITS'(1);
      end else if (buffer_capacity > CAP_BITS'(SLOTS)) begin
         cap_eff = COUNT_BITS'(SLOTS);
      end else begin
         cap_eff = COUNT_BITS'(buffer_capacity);
      end
   end

   always_comb begin
      hit         = 1'b0;
      hit_slot    = '0;
      free_found  = 1'b0;
      free_slot   = '0;
      best_rank   = '0;
      victim_slot = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid_ff[i] && slot_page_ff[i] == page && !hit) begin
            hit      = 1'b1;
            hit_slot = SLOT_BITS'(i);
         end
         if (!slot_valid_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_slot  = SLOT_BITS'(i);
         end
         if (slot_valid_ff[i] && slot_rank_ff[i] >= best_rank) begin
            best_rank   = slot_rank_ff[i];
            victim_slot = SLOT_BITS'(i);
         end
      end
   end

   assign fill  = !hit && (count < cap_eff);
   assign evict = !hit && !fill;
   assign sel   = hit ? hit_slot : (fill ? free_slot : victim_slot);

   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_page_in  = slot_page_ff;
      slot_dirty_in = slot_dirty_ff;
      slot_rank_in  = slot_rank_ff;
      if (enable && in_range) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (SLOT_BITS'(i) != sel && slot_valid_ff[i] &&
                (fill || slot_rank_ff[i] < slot_rank_ff[sel])) begin
               slot_rank_in[i] = slot_rank_ff[i] + 1'b1;
            end
         end
         slot_rank_in[sel]  = '0;
         slot_valid_in[sel] = 1'b1;
         if (!hit) begin
            slot_page_in[sel]  = page;
            slot_dirty_in[sel] = 1'b0;
         end
         if (operation == OP_WRITE) begin
            slot_dirty_in[sel] = 1'b1;
         end
      end
   end

   always_comb begin
      result = '0;
      if (in_range) begin
         result.status           = STATUS_OK;
         result.hit              = hit;
         result.slot             = sel;
         result.page_number      = page;
         result.page_offset      = offset;
         result.evict_valid      = evict;
         result.evicted_page     = evict ? slot_page_ff[sel] : '0;
         result.writeback_needed = evict && slot_dirty_ff[sel];
      end else begin
         result.status = STATUS_REJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         slot_page_ff  <= '0;
         slot_dirty_ff <= '0;
         slot_rank_ff  <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         slot_page_ff  <= slot_page_in;
         slot_dirty_ff <= slot_dirty_in;
         slot_rank_ff  <= slot_rank_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> $countones(slot_valid_ff) >= $past($countones(slot_valid_ff)))
      else $error("resident slot count decreased");

   assert property (@(posedge clock) disable iff (reset)
      (enable && result.hit) |-> slot_valid_ff[result.slot])
      else $error("hit reported on an empty slot");

   assert property (@(posedge clock) disable iff (reset)
      (enable && result.status == STATUS_OK) |=>
         slot_valid_ff[$past(result.slot)] && slot_rank_ff[$past(result.slot)] == '0)
      else $error("accessed slot is not valid and most recent");

   assert property (@(posedge clock) disable iff (reset)
      (enable && result.status == STATUS_REJECT) |=>
         $stable(slot_valid_ff) && $stable(slot_page_ff) &&
         $stable(slot_dirty_ff) && $stable(slot_rank_ff))
      else $error("rejected access changed the directory");
`endif

endmodule

// ===== src/lru_writeback_page_buffer.sv =====
// ----------------------------------------------------------------------------
// LRU write-back page buffer
// Fully associative page directory with exact LRU replacement and dirty
// tracking, behind a registered request stage and a registered response.
// ----------------------------------------------------------------------------
// The block takes one access per clock cycle while the response is not
// stalled. The request is registered, the directory lookup, victim choice and
// rank update run on the registered request, and the response register is
// loaded at the edge where the response stage advances. Slot state is updated
// at that same edge, so each access sees every earlier one. A stalled response
// holds the pipeline; with no stall the sustained rate is one access per cycle.
// The csr_ registers take effect at once and must be written while no access
// is in flight; the block itself does not enforce this.
module lru_writeback_page_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [lwpb_pkg::INDEX_BITS-1:0]     req_element_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic                                rsp_hit,
   output logic [lwpb_pkg::SLOT_BITS-1:0]      rsp_slot,
   output logic [lwpb_pkg::PAGE_BITS-1:0]      rsp_page_number,
   output logic [lwpb_pkg::OFFSET_BITS-1:0]    rsp_page_offset,
   output logic                                rsp_evict_valid,
   output logic [lwpb_pkg::PAGE_BITS-1:0]      rsp_evicted_page,
   output logic                                rsp_writeback_needed,
   input  logic                                csr_write,
   input  logic [lwpb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lwpb_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import lwpb_pkg::*;

   logic [CAP_BITS-1:0]   capacity_ff, capacity_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;
   logic                  req_valid_ff, req_valid_in;
   logic                  op_ff, op_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lwpb_result_type       rsp_ff, rsp_in;
   lwpb_result_type       dir_result;
   logic                  advance;
   logic                  load;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      capacity_in = capacity_ff;
      size_in     = size_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BUFFER_CAPACITY: capacity_in = csr_wdata[CAP_BITS-1:0];
            CSR_ARRAY_SIZE:      size_in     = csr_wdata[SIZE_BITS-1:0];
            default:             ;
         endcase
      end
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      op_in        = op_ff;
      index_in     = index_ff;
      if (!req_valid_ff || advance) begin
         req_valid_in = req_valid;
      end
      if (load) begin
         op_in    = req_operation;
         index_in = req_element_index;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
         if (req_valid_ff) begin
            rsp_in = dir_result;
         end
      end
   end

   lwpb_directory u_directory (
      .clock           (clock),
      .reset           (reset),
      .enable          (req_valid_ff && advance),
      .operation       (op_ff),
      .element_index   (index_ff),
      .buffer_capacity (capacity_ff),
      .array_size      (size_ff),
      .result          (dir_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         size_ff      <= SIZE_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         size_ff      <= size_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      index_ff <= index_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_hit              = rsp_ff.hit;
   assign rsp_slot             = rsp_ff.slot;
   assign rsp_page_number      = rsp_ff.page_number;
   assign rsp_page_offset      = rsp_ff.page_offset;
   assign rsp_evict_valid      = rsp_ff.evict_valid;
   assign rsp_evicted_page     = rsp_ff.evicted_page;
   assign rsp_writeback_needed = rsp_ff.writeback_needed;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU write-back page buffer testbench
// Drives read and write accesses through the request channel and predicts
// every response with its own model of the page directory: hit search, free
// slot fill, exact LRU eviction, dirty tracking and range rejection. Sender
// and receiver idle at random; phases change capacity and array size while
// the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import lwpb_pkg::*;

   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          MAX_REPORTS  = 60;
   localparam int unsigned INDEX_SPAN   = 32'h0100_0000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_operation = OP_READ;
   logic [INDEX_BITS-1:0]     req_element_index = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_status;
   logic                      rsp_hit;
   logic [SLOT_BITS-1:0]      rsp_slot;
   logic [PAGE_BITS-1:0]      rsp_page_number;
   logic [OFFSET_BITS-1:0]    rsp_page_offset;
   logic                      rsp_evict_valid;
   logic [PAGE_BITS-1:0]      rsp_evicted_page;
   logic                      rsp_writeback_needed;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Directory model.
   logic                   dir_valid [SLOTS];
   logic [PAGE_BITS-1:0]   dir_page  [SLOTS];
   logic                   dir_dirty [SLOTS];
   logic [SLOT_BITS-1:0]   dir_rank  [SLOTS];
   logic [CAP_BITS-1:0]    model_capacity   = CAP_RESET;
   logic [SIZE_BITS-1:0]   model_array_size = SIZE_RESET;

   lwpb_result_type pending_responses [$];

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int rsp_hold_request = 0;
   int error_count = 0;
   int cycle_count = 0;
   int accesses_sent = 0;
   int responses_checked = 0;
   int hit_count = 0;
   int eviction_count = 0;
   int writeback_count = 0;
   int reject_count = 0;

   lru_writeback_page_buffer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_element_index    (req_element_index),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_hit              (rsp_hit),
      .rsp_slot             (rsp_slot),
      .rsp_page_number      (rsp_page_number),
      .rsp_page_offset      (rsp_page_offset),
      .rsp_evict_valid      (rsp_evict_valid),
      .rsp_evicted_page     (rsp_evicted_page),
      .rsp_writeback_needed (rsp_writeback_needed),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         dir_valid[i] = 1'b0;
         dir_page[i]  = '0;
         dir_dirty[i] = 1'b0;
         dir_rank[i]  = '0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding", $time,
                  cycle_count, pending_responses.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Make slot s the most recent; valid slots more recent than old_rank age by one.
   function automatic void promote_slot(int s, int old_rank);
      for (int i = 0; i < SLOTS; i++) begin
         if (i != s && dir_valid[i] && int'(dir_rank[i]) < old_rank)
            dir_rank[i] = dir_rank[i] + 1'b1;
      end
      dir_rank[s] = '0;
   endfunction

   function automatic lwpb_result_type predict_page_access(logic op,
                                                           logic [INDEX_BITS-1:0] idx);
      lwpb_result_type      r;
      logic [PAGE_BITS-1:0] page;
      int                   cap;
      int                   count;
      int                   s;
      int                   best;
      bit                   found;
      r = '0;
      if ({1'b0, idx} >= model_array_size) begin
         r.status = STATUS_REJECT;
         reject_count++;
         return r;
      end
      page = idx[INDEX_BITS-1:OFFSET_BITS];
      cap = int'(model_capacity);
      if (cap < 1) cap = 1;
      if (cap > SLOTS) cap = SLOTS;
      s = 0;
      count = 0;
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (dir_valid[i]) begin
            count++;
            if (!found && dir_page[i] == page) begin
               found = 1'b1;
               s = i;
            end
         end
      end
      if (found) begin
         promote_slot(s, int'(dir_rank[s]));
         hit_count++;
      end else if (count < cap) begin
         for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!dir_valid[i]) s = i;
         end
         dir_valid[s] = 1'b1;
         dir_page[s]  = page;
         dir_dirty[s] = 1'b0;
         promote_slot(s, SLOTS + 1);
      end else begin
         best = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (dir_valid[i] && int'(dir_rank[i]) >= best) begin
               best = int'(dir_rank[i]);
               s = i;
            end
         end
         r.evict_valid      = 1'b1;
         r.evicted_page     = dir_page[s];
         r.writeback_needed = dir_dirty[s];
         eviction_count++;
         if (dir_dirty[s]) writeback_count++;
         dir_page[s]  = page;
         dir_dirty[s] = 1'b0;
         promote_slot(s, int'(dir_rank[s]));
      end
      if (op == OP_WRITE) dir_dirty[s] = 1'b1;
      r.status      = STATUS_OK;
      r.hit         = found;
      r.slot        = s[SLOT_BITS-1:0];
      r.page_number = page;
      r.page_offset = idx[OFFSET_BITS-1:0];
      return r;
   endfunction

   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   // Response side: the transfer is decided from values settled at the falling
   // edge and takes place at the following rising edge.
   initial begin : response_monitor
      lwpb_result_type exp_r;
      bit              took;
      int              hold;
      took = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         took = !reset && rsp_valid && !rsp_stall;
         if (took) begin
            responses_checked++;
            if (pending_responses.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: response with none expected, expected none, actual page %0h",
                           $time, rsp_page_number);
            end else begin
               exp_r = pending_responses.pop_front();
               check_field("status", exp_r.status, rsp_status);
               check_field("hit", exp_r.hit, rsp_hit);
               check_field("slot", exp_r.slot, rsp_slot);
               check_field("page_number", exp_r.page_number, rsp_page_number);
               check_field("page_offset", exp_r.page_offset, rsp_page_offset);
               check_field("evict_valid", exp_r.evict_valid, rsp_evict_valid);
               check_field("evicted_page", exp_r.evicted_page, rsp_evicted_page);
               check_field("writeback_needed", exp_r.writeback_needed,
                           rsp_writeback_needed);
            end
         end
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            hold = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (took && rsp_idle_on) begin
            hold = $urandom_range(0, 16);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               hold--;
            end else begin
               rsp_stall <= 1'b0;
            end
         end else begin
            rsp_stall <= rsp_idle_on && ($urandom_range(0, 7) == 0);
         end
      end
   end

   // Called and returning at a rising edge; returns at the edge of the transfer.
   task automatic send_access(logic op, logic [INDEX_BITS-1:0] idx);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_element_index <= idx;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      pending_responses.push_back(predict_page_access(op, idx));
      accesses_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index,
                            logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_BUFFER_CAPACITY)
         model_capacity = data[CAP_BITS-1:0];
      else
         model_array_size = data;
      @(posedge clock);
   endtask

   // Mostly accesses to a small set of pages, so that hits, fills and
   // evictions all occur, with some fully random and boundary indices.
   task automatic send_pool_traffic(int n, int pool_base, int pool_n);
      int unsigned           size_lim;
      int unsigned           page;
      int unsigned           wide_idx;
      int                    pick;
      logic [INDEX_BITS-1:0] idx;
      for (int k = 0; k < n; k++) begin
         size_lim = (model_array_size > INDEX_SPAN) ? INDEX_SPAN : int'(model_array_size);
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            wide_idx = $urandom;
         end else if (pick == 1 && size_lim > 0) begin
            wide_idx = size_lim - 1 + $urandom_range(0, 1);
         end else begin
            page = pool_base + $urandom_range(0, pool_n - 1);
            wide_idx = page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
            if (size_lim > 0 && size_lim < INDEX_SPAN) wide_idx = wide_idx % size_lim;
         end
         idx = wide_idx[INDEX_BITS-1:0];
         send_access($urandom_range(0, 1) ? OP_WRITE : OP_READ, idx);
      end
   endtask

   task automatic test_reset_defaults();
      send_access(OP_READ, '0);
      send_access(OP_WRITE, '0);
      send_access(OP_READ, '1);
      send_access(OP_WRITE, '1);
   endtask

   task automatic test_directed();
      wait_idle();
      write_csr(CSR_ARRAY_SIZE, 25'(INDEX_SPAN));
      write_csr(CSR_BUFFER_CAPACITY, 4'd8);
      send_access(OP_WRITE, '0);
      send_access(OP_READ, '1);
      send_access(OP_READ, 24'(PAGE_BYTES - 1));
      for (int p = 2; p < 8; p++)
         send_access((p % 2) ? OP_READ : OP_WRITE, 24'(p * PAGE_BYTES + p));
      // The next two misses push out a clean page and then the dirty page 0.
      send_access(OP_READ, 24'(100 * PAGE_BYTES));
      send_access(OP_READ, 24'(101 * PAGE_BYTES + 7));
      // Capacity zero acts as one, with all eight pages still resident.
      wait_idle();
      write_csr(CSR_BUFFER_CAPACITY, 4'd0);
      send_access(OP_WRITE, 24'(200 * PAGE_BYTES + 3));
      send_access(OP_READ, 24'(200 * PAGE_BYTES + 4));
      send_access(OP_READ, 24'(201 * PAGE_BYTES));
      wait_idle();
      write_csr(CSR_BUFFER_CAPACITY, 4'd15);
      send_access(OP_READ, 24'(300 * PAGE_BYTES));
      wait_idle();
      write_csr(CSR_ARRAY_SIZE, 25'd1000);
      send_access(OP_WRITE, 24'd999);
      send_access(OP_READ, 24'd1000);
      send_access(OP_WRITE, '1);
   endtask

   task automatic test_random_traffic(int phases, int per_phase);
      int cap;
      int eff_cap;
      int pool_n;
      int pool_base;
      logic [SIZE_BITS-1:0] size;
      for (int ph = 0; ph < phases; ph++) begin
         case (ph)
            0:       cap = 1;
            1:       cap = 8;
            2:       cap = 0;
            3:       cap = 15;
            default: cap = $urandom_range(1, 8);
         endcase
         case (ph % 4)
            0:       size = 25'(INDEX_SPAN);
            1:       size = '1;
            2:       size = 25'($urandom_range(PAGE_BYTES, INDEX_SPAN));
            default: size = 25'($urandom_range(1, 8 * PAGE_BYTES));
         endcase
         eff_cap = (cap < 1) ? 1 : ((cap > SLOTS) ? SLOTS : cap);
         pool_n = eff_cap + $urandom_range(0, 3);
         pool_base = $urandom_range(0, (1 << PAGE_BITS) - 1 - pool_n);
         wait_idle();
         write_csr(CSR_BUFFER_CAPACITY, 4'(cap));
         write_csr(CSR_ARRAY_SIZE, size);
         send_pool_traffic(per_phase, pool_base, pool_n);
      end
   endtask

   task automatic test_full_rate();
      wait_idle();
      write_csr(CSR_BUFFER_CAPACITY, 4'd4);
      write_csr(CSR_ARRAY_SIZE, 25'(INDEX_SPAN));
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_pool_traffic(100, $urandom_range(0, 1000), 6);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      wait_idle();
      write_csr(CSR_BUFFER_CAPACITY, 4'd8);
      req_idle_on = 1'b0;
      rsp_hold_request = 300;
      send_pool_traffic(60, $urandom_range(0, 1000), 10);
      req_idle_on = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_random_traffic(12, 140);
      test_full_rate();
      test_backpressure();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Sent %0d accesses and checked %0d responses over several capacity and size settings.",
               accesses_sent, responses_checked);
      $display("Predicted %0d hits, %0d evictions, %0d write-backs and %0d rejected indices.",
               hit_count, eviction_count, writeback_count, reject_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
